// File: src/assert_macros.svh
// Assertion macros for the RTL of the netlist simulator.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk_i, rst_n_i, prop, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk_i, rst_n_i, cond, msg) \
	`ASSERT_AT(label, clk_i, rst_n_i, !(cond), msg)

`endif

// File: src/tvns_pkg.sv
// Package for the three-valued netlist simulator: codes, defaults and
// the three-valued logic helpers. Depends on nothing.
package tvns_pkg;

	// Default sizes of the netlist tables.
	localparam int DEF_MAX_NODES   = 1024;
	localparam int DEF_MAX_FANIN   = 8;
	localparam int DEF_MAX_OUTPUTS = 64;

	// Width of a stored fan-in count (holds up to thirty-one).
	localparam int CNT_W = 5;

	// Request operations.
	localparam logic [1:0] OP_DEFINE   = 2'd0;
	localparam logic [1:0] OP_EDGE     = 2'd1;
	localparam logic [1:0] OP_PATTERN  = 2'd2;
	localparam logic [1:0] OP_SIMULATE = 2'd3;

	// Node kinds.
	localparam logic [3:0] KIND_NONE   = 4'd0;
	localparam logic [3:0] KIND_INPUT  = 4'd1;
	localparam logic [3:0] KIND_BRANCH = 4'd2;
	localparam logic [3:0] KIND_BUFFER = 4'd3;
	localparam logic [3:0] KIND_NOT    = 4'd4;
	localparam logic [3:0] KIND_AND    = 4'd5;
	localparam logic [3:0] KIND_NAND   = 4'd6;
	localparam logic [3:0] KIND_OR     = 4'd7;
	localparam logic [3:0] KIND_NOR    = 4'd8;
	localparam logic [3:0] KIND_XOR    = 4'd9;
	localparam logic [3:0] KIND_XNOR   = 4'd10;

	// Logic values.
	localparam logic [1:0] LV_0 = 2'd0;
	localparam logic [1:0] LV_1 = 2'd1;
	localparam logic [1:0] LV_X = 2'd2;

	// One entry of the node table.
	typedef struct packed {
		logic [3:0]       kind;
		logic             mark;
		logic [CNT_W-1:0] cnt;
	} node_word_t;

	// Three-valued inversion.
	function automatic logic [1:0] inv3(input logic [1:0] a);
		logic [1:0] r;
		case (a)
			LV_0:    r = LV_1;
			LV_1:    r = LV_0;
			default: r = LV_X;
		endcase
		return r;
	endfunction

	// Three-valued AND: a zero wins over X.
	function automatic logic [1:0] and3(input logic [1:0] a, input logic [1:0] b);
		logic [1:0] r;
		if (a == LV_0 || b == LV_0) begin
			r = LV_0;
		end else if (a == LV_1 && b == LV_1) begin
			r = LV_1;
		end else begin
			r = LV_X;
		end
		return r;
	endfunction

	// Three-valued OR: a one wins over X.
	function automatic logic [1:0] or3(input logic [1:0] a, input logic [1:0] b);
		logic [1:0] r;
		if (a == LV_1 || b == LV_1) begin
			r = LV_1;
		end else if (a == LV_0 && b == LV_0) begin
			r = LV_0;
		end else begin
			r = LV_X;
		end
		return r;
	endfunction

	// Parity that turns unknown as soon as any term is unknown.
	function automatic logic [1:0] xor3(input logic [1:0] a, input logic [1:0] b);
		logic [1:0] r;
		if (a == LV_X || b == LV_X) begin
			r = LV_X;
		end else begin
			r = {1'b0, a[0] ^ b[0]};
		end
		return r;
	endfunction

endpackage

// File: src/three_valued_netlist_simulator.sv
// Top level of the three-valued netlist simulator: netlist tables in
// synchronous memories walked by one sequencer. Depends on tvns_pkg and
// assert_macros.svh.
//
// Channel   Direction  Payload
// s_axis    in         tuser: op; tdata: node_id, node_kind, is_output, fanin_node,
//                      pattern_value
// m_axis    out        tdata: output_position, logic_value, fanin_overflow; tlast: last
// cfg       in         cfg_wdata: last_node
//
// After reset a clearing pass over all MAX_NODES entries empties the node and value tables;
// no request is taken meanwhile, configuration writes are.
// Define and pattern requests complete on acceptance; a fan-in edge passes through accept,
// count read, then write.
// A simulate request reads and evaluates each node, reads each fan-in as source, value,
// then accumulate, writes back the result, then walks the nodes once more for the outputs;
// the single read port of the value table sets this sequence.
// A result waiting on m_axis stalls only the output walk, one result deep.
`include "assert_macros.svh"

module three_valued_netlist_simulator
	import tvns_pkg::*;
#(
	parameter int MAX_NODES   = DEF_MAX_NODES,
	parameter int MAX_FANIN   = DEF_MAX_FANIN,
	parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [9:0] node_id, [13:10] node_kind, [14] is_output, [24:15] fanin_node,
	// [26:25] pattern_value, [31:27] zero
	input  logic [31:0] s_axis_tdata,
	// [1:0] op
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [5:0] output_position, [7:6] logic_value, [8] fanin_overflow, [15:9] zero
	output logic [15:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int FAW = $clog2(MAX_NODES * MAX_FANIN);
	localparam int OCW = $clog2(MAX_OUTPUTS + 1);

	// Sequencer states.
	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_EDGE_RD = 4'd2;
	localparam logic [3:0] ST_EDGE_WR = 4'd3;
	localparam logic [3:0] ST_N_RD    = 4'd4;
	localparam logic [3:0] ST_N_EV    = 4'd5;
	localparam logic [3:0] ST_F_RD    = 4'd6;
	localparam logic [3:0] ST_F_SRC   = 4'd7;
	localparam logic [3:0] ST_F_ACC   = 4'd8;
	localparam logic [3:0] ST_WRITE   = 4'd9;
	localparam logic [3:0] ST_O_RD    = 4'd10;
	localparam logic [3:0] ST_O_CHK   = 4'd11;
	localparam logic [3:0] ST_O_END   = 4'd12;

	// Request fields.
	logic [1:0] in_op;
	logic [9:0] in_id;
	logic [3:0] in_kind;
	logic       in_po;
	logic [9:0] in_src;
	logic [1:0] in_pv;

	assign in_op   = s_axis_tuser;
	assign in_id   = s_axis_tdata[9:0];
	assign in_kind = s_axis_tdata[13:10];
	assign in_po   = s_axis_tdata[14];
	assign in_src  = s_axis_tdata[24:15];
	assign in_pv   = s_axis_tdata[26:25];

	// Memories.
	node_word_t node_mem [MAX_NODES];
	logic [1:0] val_mem  [MAX_NODES];
	logic [1:0] pat_mem  [MAX_NODES];
	logic [9:0] fan_mem  [MAX_NODES * MAX_FANIN];

	logic             nm_we, nm_re, vm_we, vm_re, pm_we, pm_re, fm_we, fm_re;
	logic [NW-1:0]    nm_wa, nm_ra, vm_wa, vm_ra, pm_wa;
	logic [FAW-1:0]   fm_wa, fm_ra;
	node_word_t       nm_wd, node_rd;
	logic [1:0]       vm_wd, val_rd, pm_wd, pat_rd;
	logic [9:0]       fm_wd, fan_rd;

	// Control registers.
	logic [3:0]       state_q;
	logic [NW-1:0]    clr_q, n_q, id_q;
	logic [NW:0]      pi_q, pwc_q;
	logic [9:0]       src_q;
	logic [9:0]       last_node_q;
	logic [CNT_W-1:0] k_q, lim_q;
	logic [3:0]       kind_q;
	logic [1:0]       acc_q;
	logic [FAW-1:0]   base_q;
	logic             oob_q, ovf_q;
	logic [OCW-1:0]   nres_q;
	logic             hold_v_q;
	logic [5:0]       hold_pos_q;
	logic [1:0]       hold_val_q;
	logic             out_valid_q, out_last_q, out_ovf_q;
	logic [5:0]       out_pos_q;
	logic [1:0]       out_val_q;

	// Derived control.
	logic          in_fire, id_ok, out_free, n_at_top, take;
	logic [NW-1:0] top;
	logic [1:0]    fan_val, acc_next, result;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign id_ok         = (32'(in_id) < MAX_NODES);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign top           = (32'(last_node_q) < MAX_NODES) ? NW'(last_node_q)
	                                                      : NW'(MAX_NODES - 1);
	assign n_at_top      = (n_q == top);
	assign take          = node_rd.mark && (32'(nres_q) < MAX_OUTPUTS);
	assign fan_val       = oob_q ? LV_X : val_rd;

	// Fold one fan-in value into the running value of the gate.
	always_comb begin
		case (kind_q)
			KIND_AND, KIND_NAND:             acc_next = and3(acc_q, fan_val);
			KIND_OR, KIND_NOR:               acc_next = or3(acc_q, fan_val);
			KIND_XOR, KIND_XNOR:             acc_next = xor3(acc_q, fan_val);
			default:                         acc_next = fan_val;
		endcase
	end

	// Inverting gates complement the folded value.
	always_comb begin
		case (kind_q)
			KIND_NOT, KIND_NAND, KIND_NOR, KIND_XNOR: result = inv3(acc_q);
			default:                                  result = acc_q;
		endcase
	end

	// Memory port control, decoded from the state.
	always_comb begin
		nm_we = 1'b0; nm_wa = clr_q; nm_wd = '0;
		nm_re = 1'b0; nm_ra = n_q;
		vm_we = 1'b0; vm_wa = clr_q; vm_wd = LV_X;
		vm_re = 1'b0; vm_ra = n_q;
		pm_we = 1'b0; pm_wa = pwc_q[NW-1:0]; pm_wd = (in_pv == 2'd3) ? LV_X : in_pv;
		pm_re = 1'b0;
		fm_we = 1'b0; fm_wa = FAW'(32'(id_q) * MAX_FANIN + 32'(node_rd.cnt));
		fm_wd = src_q;
		fm_re = 1'b0; fm_ra = FAW'(32'(base_q) + 32'(k_q));
		unique case (state_q)
			ST_CLEAR: begin
				nm_we = 1'b1;
				vm_we = 1'b1;
			end
			ST_IDLE: begin
				if (in_fire && in_op == OP_DEFINE && id_ok) begin
					nm_we = 1'b1;
					nm_wa = NW'(in_id);
					nm_wd = '{kind: in_kind, mark: in_po, cnt: '0};
				end
				if (in_fire && in_op == OP_EDGE) begin
					nm_re = 1'b1;
					nm_ra = NW'(in_id);
				end
				if (in_fire && in_op == OP_PATTERN && 32'(pwc_q) < MAX_NODES) begin
					pm_we = 1'b1;
				end
			end
			ST_EDGE_WR: begin
				if (32'(node_rd.cnt) < MAX_FANIN) begin
					fm_we = 1'b1;
					nm_we = 1'b1;
					nm_wa = id_q;
					nm_wd = '{kind: node_rd.kind, mark: node_rd.mark,
					          cnt: CNT_W'(node_rd.cnt + 1'b1)};
				end
			end
			ST_N_RD: begin
				nm_re = 1'b1;
				pm_re = 1'b1;
			end
			ST_F_RD: begin
				fm_re = 1'b1;
			end
			ST_F_SRC: begin
				vm_re = 1'b1;
				vm_ra = NW'(fan_rd);
			end
			ST_WRITE: begin
				vm_we = 1'b1;
				vm_wa = n_q;
				vm_wd = result;
			end
			ST_O_RD: begin
				nm_re = 1'b1;
				vm_re = 1'b1;
			end
			ST_EDGE_RD, ST_N_EV, ST_F_ACC, ST_O_CHK, ST_O_END: begin
			end
			default: begin
			end
		endcase
	end

	// Node table.
	always_ff @(posedge clk) begin
		if (nm_we) begin
			node_mem[nm_wa] <= nm_wd;
		end
		if (nm_re) begin
			node_rd <= node_mem[nm_ra];
		end
	end

	// Value table.
	always_ff @(posedge clk) begin
		if (vm_we) begin
			val_mem[vm_wa] <= vm_wd;
		end
		if (vm_re) begin
			val_rd <= val_mem[vm_ra];
		end
	end

	// Pattern queue.
	always_ff @(posedge clk) begin
		if (pm_we) begin
			pat_mem[pm_wa] <= pm_wd;
		end
		if (pm_re) begin
			pat_rd <= pat_mem[pi_q[NW-1:0]];
		end
	end

	// Fan-in source table.
	always_ff @(posedge clk) begin
		if (fm_we) begin
			fan_mem[fm_wa] <= fm_wd;
		end
		if (fm_re) begin
			fan_rd <= fan_mem[fm_ra];
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_node_q <= '0;
		end else if (cfg_we) begin
			last_node_q <= cfg_wdata;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			n_q         <= '0;
			pi_q        <= '0;
			pwc_q       <= '0;
			ovf_q       <= 1'b0;
			nres_q      <= '0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= NW'(clr_q + 1'b1);
					if (32'(clr_q) == MAX_NODES - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						id_q  <= NW'(in_id);
						src_q <= in_src;
						unique case (in_op)
							OP_EDGE: begin
								if (id_ok) begin
									state_q <= ST_EDGE_RD;
								end
							end
							OP_PATTERN: begin
								if (32'(pwc_q) < MAX_NODES) begin
									pwc_q <= (NW+1)'(pwc_q + 1'b1);
								end
							end
							OP_SIMULATE: begin
								n_q      <= '0;
								pi_q     <= '0;
								nres_q   <= '0;
								hold_v_q <= 1'b0;
								state_q  <= ST_N_RD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_EDGE_RD: begin
					state_q <= ST_EDGE_WR;
				end
				ST_EDGE_WR: begin
					if (32'(node_rd.cnt) >= MAX_FANIN) begin
						ovf_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_N_RD: begin
					state_q <= ST_N_EV;
				end
				ST_N_EV: begin
					kind_q <= node_rd.kind;
					base_q <= FAW'(32'(n_q) * MAX_FANIN);
					k_q    <= '0;
					case (node_rd.kind)
						KIND_INPUT: begin
							acc_q   <= (pi_q < pwc_q) ? pat_rd : LV_X;
							pi_q    <= (NW+1)'(pi_q + 1'b1);
							state_q <= ST_WRITE;
						end
						KIND_BRANCH, KIND_BUFFER, KIND_NOT: begin
							acc_q   <= LV_X;
							lim_q   <= (node_rd.cnt != '0) ? CNT_W'(1) : '0;
							state_q <= (node_rd.cnt != '0) ? ST_F_RD : ST_WRITE;
						end
						KIND_AND, KIND_NAND, KIND_OR, KIND_NOR, KIND_XOR,
						KIND_XNOR: begin
							acc_q   <= (node_rd.kind == KIND_AND ||
							            node_rd.kind == KIND_NAND) ? LV_1 : LV_0;
							lim_q   <= node_rd.cnt;
							state_q <= (node_rd.cnt != '0) ? ST_F_RD : ST_WRITE;
						end
						default: begin
							// Undefined node keeps its previous value.
							if (n_at_top) begin
								n_q     <= '0;
								pwc_q   <= '0;
								state_q <= ST_O_RD;
							end else begin
								n_q     <= NW'(n_q + 1'b1);
								state_q <= ST_N_RD;
							end
						end
					endcase
				end
				ST_F_RD: begin
					state_q <= ST_F_SRC;
				end
				ST_F_SRC: begin
					oob_q   <= !(32'(fan_rd) < MAX_NODES);
					state_q <= ST_F_ACC;
				end
				ST_F_ACC: begin
					acc_q <= acc_next;
					k_q   <= CNT_W'(k_q + 1'b1);
					state_q <= (CNT_W'(k_q + 1'b1) == lim_q) ? ST_WRITE : ST_F_RD;
				end
				ST_WRITE: begin
					if (n_at_top) begin
						n_q     <= '0;
						pwc_q   <= '0;
						state_q <= ST_O_RD;
					end else begin
						n_q     <= NW'(n_q + 1'b1);
						state_q <= ST_N_RD;
					end
				end
				ST_O_RD: begin
					state_q <= ST_O_CHK;
				end
				ST_O_CHK: begin
					// The held result leaves once the next one is known.
					if (!(take && hold_v_q && !out_free)) begin
						if (take) begin
							if (hold_v_q) begin
								out_valid_q <= 1'b1;
								out_pos_q   <= hold_pos_q;
								out_val_q   <= hold_val_q;
								out_last_q  <= 1'b0;
								out_ovf_q   <= ovf_q;
							end
							hold_v_q   <= 1'b1;
							hold_pos_q <= 6'(nres_q);
							hold_val_q <= val_rd;
							nres_q     <= OCW'(nres_q + 1'b1);
						end
						if (n_at_top) begin
							state_q <= ST_O_END;
						end else begin
							n_q     <= NW'(n_q + 1'b1);
							state_q <= ST_O_RD;
						end
					end
				end
				ST_O_END: begin
					if (!hold_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_pos_q   <= hold_pos_q;
						out_val_q   <= hold_val_q;
						out_last_q  <= 1'b1;
						out_ovf_q   <= ovf_q;
						hold_v_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_ovf_q, out_val_q, out_pos_q};
	assign m_axis_tlast  = out_last_q;

	// Checks on the sequencer.
	`ASSERT_NEVER(a_no_request_in_pass, clk, arst_n,
		s_axis_tready && state_q != ST_IDLE, "request taken outside idle")
	`ASSERT_AT(a_result_bound, clk, arst_n,
		32'(nres_q) <= MAX_OUTPUTS, "result count beyond output bound")
	`ASSERT_AT(a_queue_bound, clk, arst_n,
		32'(pwc_q) <= MAX_NODES, "pattern queue beyond its depth")
	`ASSERT_NEVER(a_no_result_in_clear, clk, arst_n,
		state_q == ST_CLEAR && out_valid_q, "result during clearing pass")

endmodule

// File: tb/sv/three_valued_netlist_simulator_tb.sv
// Self-checking testbench for the three-valued netlist simulator: loads netlists,
// queues patterns and runs passes while a scoreboard predicts every output value.
// Depends on tvns_pkg and the three_valued_netlist_simulator top level.
module three_valued_netlist_simulator_tb;
	import tvns_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES        = 1024;
	localparam int FANIN        = 8;
	localparam int OUTPUTS      = 64;
	localparam int LIMIT_CYCLES = 1000000;

	// One expected output of a simulation pass.
	typedef struct {
		logic [5:0] position;
		logic [1:0] value;
		logic       last;
		logic       overflow;
	} sim_result_t;

	// Netlist state, pass prediction and comparison of the emitted values.
	class netlist_scoreboard;
		logic [3:0]  kind_tab[NODES];
		logic        mark_tab[NODES];
		int          count_tab[NODES];
		logic [9:0]  source_tab[NODES*FANIN];
		logic [1:0]  value_tab[NODES];
		logic [1:0]  pattern_tab[NODES];
		int          queued_values;
		logic        overflow;
		int          last_node;
		sim_result_t pending[$];
		int          errors;

		function new();
			for (int i = 0; i < NODES; i++) begin
				kind_tab[i] = KIND_NONE;
				mark_tab[i] = 1'b0;
				count_tab[i] = 0;
				value_tab[i] = LV_X;
				pattern_tab[i] = LV_X;
			end
			for (int i = 0; i < NODES*FANIN; i++) begin
				source_tab[i] = '0;
			end
			queued_values = 0;
			overflow = 1'b0;
			last_node = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function logic [1:0] invert(logic [1:0] a);
			if (a == LV_0) return LV_1;
			if (a == LV_1) return LV_0;
			return LV_X;
		endfunction

		function logic [1:0] gate_node(int n, ref int inp);
			logic [1:0] acc;
			logic [1:0] v;
			int         cnt;
			cnt = count_tab[n];
			acc = LV_X;
			case (kind_tab[n])
				KIND_INPUT: begin
					acc = (inp < queued_values) ? pattern_tab[inp] : LV_X;
					inp++;
				end
				KIND_BRANCH, KIND_BUFFER: begin
					acc = cnt ? value_tab[source_tab[n*FANIN]] : LV_X;
				end
				KIND_NOT: begin
					acc = cnt ? invert(value_tab[source_tab[n*FANIN]]) : LV_X;
				end
				KIND_AND, KIND_NAND: begin
					// A zero dominates; otherwise any unknown leaves the result unknown.
					acc = LV_1;
					for (int k = 0; k < cnt; k++) begin
						v = value_tab[source_tab[n*FANIN+k]];
						if (acc == LV_0 || v == LV_0) acc = LV_0;
						else if (acc == LV_X || v == LV_X) acc = LV_X;
					end
					if (kind_tab[n] == KIND_NAND) acc = invert(acc);
				end
				KIND_OR, KIND_NOR: begin
					acc = LV_0;
					for (int k = 0; k < cnt; k++) begin
						v = value_tab[source_tab[n*FANIN+k]];
						if (acc == LV_1 || v == LV_1) acc = LV_1;
						else if (acc == LV_X || v == LV_X) acc = LV_X;
					end
					if (kind_tab[n] == KIND_NOR) acc = invert(acc);
				end
				KIND_XOR, KIND_XNOR: begin
					acc = (kind_tab[n] == KIND_XOR) ? LV_0 : LV_1;
					for (int k = 0; k < cnt; k++) begin
						v = value_tab[source_tab[n*FANIN+k]];
						if (v == LV_X || acc == LV_X) acc = LV_X;
						else acc = {1'b0, acc[0] ^ v[0]};
					end
				end
				default: begin
					// Unused kinds hold whatever the node had before.
					acc = value_tab[n];
				end
			endcase
			return acc;
		endfunction

		// Applies one accepted request and queues the outputs it will cause.
		function void note_request(logic [1:0] op, logic [9:0] id, logic [3:0] kind,
				logic po, logic [9:0] src, logic [1:0] pv);
			int          inp;
			int          rank;
			sim_result_t r;
			case (op)
				OP_DEFINE: begin
					kind_tab[id] = kind;
					mark_tab[id] = po;
					count_tab[id] = 0;
				end
				OP_EDGE: begin
					if (count_tab[id] < FANIN) begin
						source_tab[id*FANIN + count_tab[id]] = src;
						count_tab[id]++;
					end else begin
						overflow = 1'b1;
					end
				end
				OP_PATTERN: begin
					if (queued_values < NODES) begin
						pattern_tab[queued_values] = (pv == 2'd3) ? LV_X : pv;
						queued_values++;
					end
				end
				default: begin
					inp = 0;
					for (int n = 0; n <= last_node; n++) begin
						value_tab[n] = gate_node(n, inp);
					end
					queued_values = 0;
					rank = 0;
					for (int n = 0; n <= last_node && rank < OUTPUTS; n++) begin
						if (mark_tab[n]) begin
							r.position = rank[5:0];
							r.value = value_tab[n];
							r.last = 1'b0;
							r.overflow = overflow;
							pending.push_back(r);
							rank++;
						end
					end
					if (rank > 0) pending[pending.size()-1].last = 1'b1;
				end
			endcase
		endfunction

		task check_result(logic [15:0] data, logic last);
			sim_result_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected output data=%h last=%b", data, last));
			end else begin
				e = pending.pop_front();
				if (data[5:0] !== e.position)
					report($sformatf("position %0d, expected %0d", data[5:0], e.position));
				if (data[7:6] !== e.value)
					report($sformatf("value %0d at position %0d, expected %0d",
						data[7:6], e.position, e.value));
				if (data[8] !== e.overflow)
					report($sformatf("overflow flag %b, expected %b", data[8], e.overflow));
				if (data[15:9] !== 7'd0)
					report($sformatf("padding bits %h not zero", data[15:9]));
				if (last !== e.last)
					report($sformatf("tlast %b at position %0d, expected %b",
						last, e.position, e.last));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [9:0]  cfg_wdata;

	netlist_scoreboard sb;
	bit                steady;
	int                cycles;

	three_valued_netlist_simulator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	// Free-running clock, 12 ns period.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// The receiver stalls at random, holding each choice for a while.
	int ready_hold;
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			ready_hold <= pick_gap();
			m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	// Every accepted output is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata, m_axis_tlast);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Sends one request and notes it once it has been taken.
	task send(logic [1:0] op, logic [9:0] id, logic [3:0] kind, logic po,
			logic [9:0] src, logic [1:0] pv);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {5'd0, pv, src, po, kind, id};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(op, id, kind, po, src, pv);
	endtask

	task define_node(int id, logic [3:0] kind, logic po);
		send(OP_DEFINE, id[9:0], kind, po, 10'($urandom), 2'($urandom));
	endtask

	task add_edge(int id, int src);
		send(OP_EDGE, id[9:0], 4'($urandom), 1'($urandom), src[9:0], 2'($urandom));
	endtask

	task push_value(logic [1:0] pv);
		send(OP_PATTERN, 10'($urandom), 4'($urandom), 1'($urandom), 10'($urandom), pv);
	endtask

	task simulate();
		send(OP_SIMULATE, 10'($urandom), 4'($urandom), 1'($urandom), 10'($urandom),
			2'($urandom));
	endtask

	// Waits for every output, then for a pass that may emit nothing.
	task wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat ((sb.last_node + 1) * 32 + 64) @(posedge clk);
	endtask

	task write_last_node(int v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v[9:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.last_node = v;
	endtask

	// One random phase: a small netlist reworked and simulated a few times.
	task random_phase(int top, int n_items);
		int r;
		int id;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			id = $urandom_range(0, top);
			if (r < 25) begin
				define_node(id, ($urandom_range(0, 9) == 0) ? 4'($urandom) :
					4'($urandom_range(1, 10)), 1'($urandom));
			end else if (r < 50) begin
				add_edge(id, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023) :
					$urandom_range(0, top));
			end else if (r < 53) begin
				// Pile edges on one gate until its fan-in bound is exceeded.
				repeat (FANIN + 2) add_edge(id, $urandom_range(0, top));
			end else if (r < 75) begin
				push_value(2'($urandom));
			end else if (r < 88) begin
				simulate();
			end else begin
				send(2'($urandom), 10'($urandom), 4'($urandom), 1'($urandom),
					10'($urandom), 2'($urandom));
			end
		end
		simulate();
	endtask

	initial begin
		sb = new();
		steady = 1'b0;
		cycles = 0;
		ready_hold = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_DEFINE;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed netlist: every kind, empty fan-ins, unused kinds, X patterns.
		write_last_node(15);
		define_node(0, KIND_INPUT, 1'b1);
		define_node(1, KIND_INPUT, 1'b0);
		define_node(2, KIND_INPUT, 1'b0);
		define_node(3, KIND_BRANCH, 1'b1);
		add_edge(3, 0);
		define_node(4, KIND_NOT, 1'b1);
		add_edge(4, 1);
		define_node(5, KIND_AND, 1'b1);
		add_edge(5, 1);
		add_edge(5, 2);
		define_node(6, KIND_NAND, 1'b1);
		define_node(7, KIND_OR, 1'b1);
		add_edge(7, 0);
		add_edge(7, 2);
		define_node(8, KIND_NOR, 1'b1);
		define_node(9, KIND_XOR, 1'b1);
		add_edge(9, 1023);
		define_node(10, KIND_XNOR, 1'b1);
		add_edge(10, 1);
		define_node(11, KIND_BUFFER, 1'b1);
		define_node(12, 4'd15, 1'b1);
		push_value(LV_0);
		push_value(LV_1);
		push_value(2'd3);
		simulate();

		// Random phases over several settings of the last node.
		write_last_node(1);
		random_phase(1, 6);
		steady = 1'b1;
		write_last_node(63);
		random_phase(63, 12);
		steady = 1'b0;
		for (int p = 0; p < 2; p++) begin
			write_last_node($urandom_range(2, 24));
			random_phase(sb.last_node, 8);
		end

		// More outputs than can be emitted, with the whole table walked.
		write_last_node(1023);
		for (int n = 0; n < OUTPUTS + 1; n++) define_node(n, KIND_INPUT, 1'b1);
		repeat (3) push_value(2'($urandom));
		simulate();
		simulate();

		// A pass with no output node in range gives nothing.
		write_last_node(0);
		define_node(0, KIND_AND, 1'b0);
		simulate();
		random_phase(0, 4);

		wait_drained();
		if (sb.pending.size() != 0) sb.report("expected outputs never arrived");
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
